// ----- rtl/fdpc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Follow-distance pitch controller package
// Shared types, constants and helper functions for the controller blocks.
// ============================================================================
package fdpc_pkg;

    // Default number of ticks between two speed setpoint refreshes.
    localparam int SETPOINT_DECIMATION_DEF = 5;

    // Field widths.
    localparam int DIST_W   = 24;
    localparam int SPEED_W  = 24;
    localparam int CFG_W    = 16;
    localparam int PITCH_W  = 16;
    localparam int ERR_W    = SPEED_W + 1;
    localparam int DERIV_W  = ERR_W + 1;
    localparam int ESUM_W   = 32;
    localparam int COEF_W   = 29;
    localparam int MUL_W    = 32;
    localparam int ACC_W    = 56;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_DIST = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SP_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_GAIN  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_MIN   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_MAX   = 3'd7;

    // Configuration reset values.
    localparam logic [CFG_W-1:0] RST_TARGET_DIST = 16'd1792;
    localparam logic [CFG_W-1:0] RST_SP_GAIN     = 16'd2048;
    localparam logic [CFG_W-1:0] RST_PROP_GAIN   = 16'd3277;
    localparam logic [CFG_W-1:0] RST_INTEG_GAIN  = 16'd0;
    localparam logic [CFG_W-1:0] RST_DERIV_GAIN  = 16'd4096;
    localparam logic [CFG_W-1:0] RST_PITCH_GAIN  = 16'd1208;
    localparam logic [CFG_W-1:0] RST_PITCH_MIN   = 16'hF4D4;
    localparam logic [CFG_W-1:0] RST_PITCH_MAX   = 16'd2860;

    // Low-pass weights, 0.9 and 0.1 scaled by 2^16.
    localparam logic signed [MUL_W-1:0] FILT_OLD = 32'sd58982;
    localparam logic signed [MUL_W-1:0] FILT_NEW = 32'sd6554;

    localparam int FRAC_SHIFT = 12;
    localparam int FILT_SHIFT = 22;
    localparam int OLD_SHIFT  = 6;

    localparam logic signed [ACC_W-1:0] FRAC_HALF = ACC_W'(1) << (FRAC_SHIFT - 1);
    localparam logic signed [ACC_W-1:0] FILT_HALF = ACC_W'(1) << (FILT_SHIFT - 1);
    localparam logic signed [ACC_W-1:0] S24_MAX = ACC_W'(24'sh7FFFFF);
    localparam logic signed [ACC_W-1:0] S24_MIN = -(ACC_W'(1) << 23);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SP_MUL,
        ST_SP_SAT,
        ST_ERR,
        ST_P_MUL,
        ST_I_MUL,
        ST_D_MUL,
        ST_K_MUL,
        ST_CMD,
        ST_T_MUL,
        ST_O_MUL,
        ST_FILT
    } t_state;

    typedef enum logic [2:0] {
        MUL_SP,
        MUL_P,
        MUL_I,
        MUL_D,
        MUL_K,
        MUL_T,
        MUL_O
    } t_mul_sel;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_NEG
    } t_acc_op;

    typedef struct packed {
        logic     load_in;
        logic     sp_sat;
        logic     err_step;
        logic     mul_en;
        t_mul_sel mul_sel;
        t_acc_op  acc_op;
        logic     cmd_sat;
        logic     filt;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

    // Round-half-up by 2^FRAC_SHIFT, then saturate to 24 bits signed.
    function automatic logic signed [SPEED_W-1:0] round_sat24(
        input logic signed [ACC_W-1:0] x
    );
        logic signed [ACC_W-1:0] t;
        t = (x + FRAC_HALF) >>> FRAC_SHIFT;
        if (t > S24_MAX) begin
            return S24_MAX[SPEED_W-1:0];
        end else if (t < S24_MIN) begin
            return S24_MIN[SPEED_W-1:0];
        end else begin
            return t[SPEED_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

// ----- rtl/fdpc_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Measurement channel
// Carries one control tick: distance to target and forward speed.
// ============================================================================
interface fdpc_in_if;
    logic                                   valid;
    logic                                   ready;
    logic        [fdpc_pkg::DIST_W-1:0]     distance;
    logic signed [fdpc_pkg::SPEED_W-1:0]    forward_speed;

    modport source (output valid, output distance, output forward_speed, input ready);
    modport sink   (input valid, input distance, input forward_speed, output ready);
endinterface
`default_nettype wire

// ----- rtl/fdpc_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Command channel
// Carries one result per tick: pitch command, speed setpoint and speed command.
// ============================================================================
interface fdpc_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [fdpc_pkg::PITCH_W-1:0]    pitch_cmd;
    logic signed [fdpc_pkg::SPEED_W-1:0]    speed_setpoint_out;
    logic signed [fdpc_pkg::SPEED_W-1:0]    speed_cmd_out;

    modport source (output valid, output pitch_cmd, output speed_setpoint_out,
                    output speed_cmd_out, input ready);
    modport sink   (input valid, input pitch_cmd, input speed_setpoint_out,
                    input speed_cmd_out, output ready);
endinterface
`default_nettype wire

// ----- rtl/follow_distance_pitch_controller.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Follow-distance pitch controller
// Cascaded distance-to-speed and speed PID loop driving a filtered pitch.
// ============================================================================
// Usage: each measurement request on i_in (distance, forward speed) is one
// control tick and yields exactly one request on o_out (pitch command, speed
// setpoint, speed command). Both channels use valid/ready; a request moves at
// a clock edge with valid and ready high.
// Every SETPOINT_DECIMATION-th tick, starting with the first after reset, the
// speed setpoint is refreshed before the PID runs.
// The next request is accepted only once the sequencer is back in idle after
// the filter step of the previous one; the pace is set by the single shared
// 32x32 multiplier, which the sequencer uses for seven products on a refresh
// tick and six on the others.
// A finished result sits in an output register, so the next tick may be
// accepted while it waits. If the receiver stalls with that register still
// full, the last step holds until it is taken.
// Reset (synchronous, active low) clears the loop state, restores the
// register defaults and empties the output register. Configuration writes
// go through i_cfg_we / i_cfg_idx / i_cfg_data, take effect at once and
// must only be made while no tick is in work.
// ============================================================================
module follow_distance_pitch_controller #(
    parameter int SETPOINT_DECIMATION = fdpc_pkg::SETPOINT_DECIMATION_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    fdpc_in_if.sink                         i_in,
    fdpc_out_if.source                      o_out,
    input  wire                             i_cfg_we,
    input  wire [fdpc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [fdpc_pkg::CFG_W-1:0]       i_cfg_data
);

    fdpc_pkg::t_dp_cmd dp_cmd;
    fdpc_pkg::t_dp_sts dp_sts;

    fdpc_ctrl #(
        .SETPOINT_DECIMATION (SETPOINT_DECIMATION)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    fdpc_datapath u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data),
        .i_distance           (i_in.distance),
        .i_forward_speed      (i_in.forward_speed),
        .i_cmd                (dp_cmd),
        .o_sts                (dp_sts),
        .o_out_valid          (o_out.valid),
        .i_out_ready          (o_out.ready),
        .o_pitch_cmd          (o_out.pitch_cmd),
        .o_speed_setpoint_out (o_out.speed_setpoint_out),
        .o_speed_cmd_out      (o_out.speed_cmd_out)
    );

endmodule
`default_nettype wire

// ----- rtl/fdpc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Follow-distance pitch controller sequencer
// Steps the datapath through setpoint, PID and filter phases of one tick.
// ============================================================================
module fdpc_ctrl #(
    parameter int SETPOINT_DECIMATION = fdpc_pkg::SETPOINT_DECIMATION_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  fdpc_pkg::t_dp_sts  i_sts,
    output fdpc_pkg::t_dp_cmd  o_cmd
);

    localparam int PHASE_W = (SETPOINT_DECIMATION > 1) ? $clog2(SETPOINT_DECIMATION) : 1;
    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(SETPOINT_DECIMATION - 1);

    fdpc_pkg::t_state r_state, n_state;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic               accept;

    assign accept = i_in_valid && (r_state == fdpc_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fdpc_pkg::ST_IDLE;
            r_phase <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            n_phase = (r_phase == PHASE_LAST) ? '0 : r_phase + PHASE_W'(1);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            fdpc_pkg::ST_IDLE: begin
                if (accept) begin
                    // The setpoint is only refreshed on the first tick of each period.
                    n_state = (r_phase == '0) ? fdpc_pkg::ST_SP_MUL : fdpc_pkg::ST_ERR;
                end
            end
            fdpc_pkg::ST_SP_MUL: n_state = fdpc_pkg::ST_SP_SAT;
            fdpc_pkg::ST_SP_SAT: n_state = fdpc_pkg::ST_ERR;
            fdpc_pkg::ST_ERR:    n_state = fdpc_pkg::ST_P_MUL;
            fdpc_pkg::ST_P_MUL:  n_state = fdpc_pkg::ST_I_MUL;
            fdpc_pkg::ST_I_MUL:  n_state = fdpc_pkg::ST_D_MUL;
            fdpc_pkg::ST_D_MUL:  n_state = fdpc_pkg::ST_K_MUL;
            fdpc_pkg::ST_K_MUL:  n_state = fdpc_pkg::ST_CMD;
            fdpc_pkg::ST_CMD:    n_state = fdpc_pkg::ST_T_MUL;
            fdpc_pkg::ST_T_MUL:  n_state = fdpc_pkg::ST_O_MUL;
            fdpc_pkg::ST_O_MUL:  n_state = fdpc_pkg::ST_FILT;
            fdpc_pkg::ST_FILT: begin
                if (i_sts.out_free) begin
                    n_state = fdpc_pkg::ST_IDLE;
                end
            end
            default: n_state = fdpc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd.load_in  = 1'b0;
        o_cmd.sp_sat   = 1'b0;
        o_cmd.err_step = 1'b0;
        o_cmd.mul_en   = 1'b0;
        o_cmd.mul_sel  = fdpc_pkg::MUL_SP;
        o_cmd.acc_op   = fdpc_pkg::ACC_HOLD;
        o_cmd.cmd_sat  = 1'b0;
        o_cmd.filt     = 1'b0;
        case (r_state)
            fdpc_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            fdpc_pkg::ST_SP_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = fdpc_pkg::MUL_SP;
            end
            fdpc_pkg::ST_SP_SAT: o_cmd.sp_sat = 1'b1;
            fdpc_pkg::ST_ERR:    o_cmd.err_step = 1'b1;
            fdpc_pkg::ST_P_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = fdpc_pkg::MUL_P;
            end
            fdpc_pkg::ST_I_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = fdpc_pkg::MUL_I;
                o_cmd.acc_op  = fdpc_pkg::ACC_LOAD;
            end
            fdpc_pkg::ST_D_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = fdpc_pkg::MUL_D;
                o_cmd.acc_op  = fdpc_pkg::ACC_ADD;
            end
            fdpc_pkg::ST_K_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = fdpc_pkg::MUL_K;
                o_cmd.acc_op  = fdpc_pkg::ACC_ADD;
            end
            fdpc_pkg::ST_CMD:    o_cmd.cmd_sat = 1'b1;
            fdpc_pkg::ST_T_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = fdpc_pkg::MUL_T;
            end
            fdpc_pkg::ST_O_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = fdpc_pkg::MUL_O;
                o_cmd.acc_op  = fdpc_pkg::ACC_NEG;
            end
            fdpc_pkg::ST_FILT:   o_cmd.filt = i_sts.out_free;
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/fdpc_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Follow-distance pitch controller datapath
// Configuration registers, loop state, one shared multiplier and output register.
// ============================================================================
module fdpc_datapath (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_cfg_we,
    input  wire  [fdpc_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  wire  [fdpc_pkg::CFG_W-1:0]             i_cfg_data,
    input  wire  [fdpc_pkg::DIST_W-1:0]            i_distance,
    input  wire  [fdpc_pkg::SPEED_W-1:0]           i_forward_speed,
    input  fdpc_pkg::t_dp_cmd                      i_cmd,
    output fdpc_pkg::t_dp_sts                      o_sts,
    output logic                                   o_out_valid,
    input  wire                                    i_out_ready,
    output logic signed [fdpc_pkg::PITCH_W-1:0]    o_pitch_cmd,
    output logic signed [fdpc_pkg::SPEED_W-1:0]    o_speed_setpoint_out,
    output logic signed [fdpc_pkg::SPEED_W-1:0]    o_speed_cmd_out
);

    localparam int ACC_W = fdpc_pkg::ACC_W;
    localparam int MUL_W = fdpc_pkg::MUL_W;

    // Configuration registers.
    logic        [fdpc_pkg::CFG_W-1:0] r_target_dist;
    logic signed [fdpc_pkg::CFG_W-1:0] r_sp_gain, r_prop_gain, r_integ_gain;
    logic signed [fdpc_pkg::CFG_W-1:0] r_deriv_gain, r_pitch_gain, r_pitch_min, r_pitch_max;

    // Loop state.
    logic signed [fdpc_pkg::SPEED_W-1:0] r_setpoint;
    logic signed [fdpc_pkg::ESUM_W-1:0]  r_esum, n_esum;
    logic signed [fdpc_pkg::ERR_W-1:0]   r_prev_err;
    logic signed [fdpc_pkg::PITCH_W-1:0] r_pitch_filt;

    // Working registers for one tick.
    logic        [fdpc_pkg::DIST_W-1:0]  r_dist;
    logic signed [fdpc_pkg::SPEED_W-1:0] r_speed;
    logic signed [fdpc_pkg::ERR_W-1:0]   r_err, n_err;
    logic signed [fdpc_pkg::DERIV_W-1:0] r_deriv;
    logic signed [fdpc_pkg::SPEED_W-1:0] r_cmd;
    logic signed [fdpc_pkg::COEF_W-1:0]  r_coef;
    logic signed [ACC_W-1:0]             r_prod, r_acc;

    // Output register.
    logic                                r_out_valid;
    logic signed [fdpc_pkg::PITCH_W-1:0] r_out_pitch;
    logic signed [fdpc_pkg::SPEED_W-1:0] r_out_sp, r_out_cmd;

    logic signed [MUL_W-1:0]             mul_a, mul_b;
    logic signed [2*MUL_W-1:0]           mul_p;
    logic signed [fdpc_pkg::ERR_W-1:0]   diff;
    logic signed [fdpc_pkg::ESUM_W:0]    esum_wide;
    logic signed [ACC_W-1:0]             filt_sum, filt_q, lim_min, lim_max;
    logic signed [fdpc_pkg::PITCH_W-1:0] pitch_new;
    logic                                out_free;

    assign out_free       = !r_out_valid || i_out_ready;
    assign o_sts.out_free = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_dist <= fdpc_pkg::RST_TARGET_DIST;
            r_sp_gain     <= fdpc_pkg::RST_SP_GAIN;
            r_prop_gain   <= fdpc_pkg::RST_PROP_GAIN;
            r_integ_gain  <= fdpc_pkg::RST_INTEG_GAIN;
            r_deriv_gain  <= fdpc_pkg::RST_DERIV_GAIN;
            r_pitch_gain  <= fdpc_pkg::RST_PITCH_GAIN;
            r_pitch_min   <= fdpc_pkg::RST_PITCH_MIN;
            r_pitch_max   <= fdpc_pkg::RST_PITCH_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fdpc_pkg::CFG_TARGET_DIST: r_target_dist <= i_cfg_data;
                fdpc_pkg::CFG_SP_GAIN:     r_sp_gain     <= i_cfg_data;
                fdpc_pkg::CFG_PROP_GAIN:   r_prop_gain   <= i_cfg_data;
                fdpc_pkg::CFG_INTEG_GAIN:  r_integ_gain  <= i_cfg_data;
                fdpc_pkg::CFG_DERIV_GAIN:  r_deriv_gain  <= i_cfg_data;
                fdpc_pkg::CFG_PITCH_GAIN:  r_pitch_gain  <= i_cfg_data;
                fdpc_pkg::CFG_PITCH_MIN:   r_pitch_min   <= i_cfg_data;
                fdpc_pkg::CFG_PITCH_MAX:   r_pitch_max   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign diff = signed'({1'b0, r_dist})
                - signed'({{(fdpc_pkg::ERR_W - fdpc_pkg::CFG_W){1'b0}}, r_target_dist});

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.mul_sel)
            fdpc_pkg::MUL_SP: begin
                mul_a = MUL_W'(r_sp_gain);
                mul_b = MUL_W'(diff);
            end
            fdpc_pkg::MUL_P: begin
                mul_a = MUL_W'(r_prop_gain);
                mul_b = MUL_W'(r_err);
            end
            fdpc_pkg::MUL_I: begin
                mul_a = MUL_W'(r_integ_gain);
                mul_b = r_esum;
            end
            fdpc_pkg::MUL_D: begin
                mul_a = MUL_W'(r_deriv_gain);
                mul_b = MUL_W'(r_deriv);
            end
            fdpc_pkg::MUL_K: begin
                mul_a = fdpc_pkg::FILT_NEW;
                mul_b = MUL_W'(r_pitch_gain);
            end
            fdpc_pkg::MUL_T: begin
                mul_a = MUL_W'(r_coef);
                mul_b = MUL_W'(r_cmd);
            end
            fdpc_pkg::MUL_O: begin
                mul_a = fdpc_pkg::FILT_OLD;
                mul_b = MUL_W'(r_pitch_filt);
            end
            default: begin
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign n_err     = signed'(ERR_W_CAST(r_setpoint)) - signed'(ERR_W_CAST(r_speed));
    assign esum_wide = (fdpc_pkg::ESUM_W + 1)'(r_esum) + (fdpc_pkg::ESUM_W + 1)'(n_err);

    always_comb begin
        if (esum_wide[fdpc_pkg::ESUM_W] != esum_wide[fdpc_pkg::ESUM_W-1]) begin
            n_esum = esum_wide[fdpc_pkg::ESUM_W]
                   ? {1'b1, {(fdpc_pkg::ESUM_W - 1){1'b0}}}
                   : {1'b0, {(fdpc_pkg::ESUM_W - 1){1'b1}}};
        end else begin
            n_esum = esum_wide[fdpc_pkg::ESUM_W-1:0];
        end
    end

    // Filter: accumulator holds the negated new-target term, product the old-value term.
    assign filt_sum = r_acc + (r_prod <<< fdpc_pkg::OLD_SHIFT) + fdpc_pkg::FILT_HALF;
    assign filt_q   = filt_sum >>> fdpc_pkg::FILT_SHIFT;
    assign lim_min  = ACC_W'(r_pitch_min);
    assign lim_max  = ACC_W'(r_pitch_max);

    // With crossed limits the lower bound is checked first.
    always_comb begin
        if (filt_q < lim_min) begin
            pitch_new = r_pitch_min;
        end else if (filt_q > lim_max) begin
            pitch_new = r_pitch_max;
        end else begin
            pitch_new = filt_q[fdpc_pkg::PITCH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_dist  <= i_distance;
            r_speed <= i_forward_speed;
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_p[ACC_W-1:0];
        end
        case (i_cmd.acc_op)
            fdpc_pkg::ACC_LOAD: r_acc <= r_prod;
            fdpc_pkg::ACC_ADD:  r_acc <= r_acc + r_prod;
            fdpc_pkg::ACC_NEG:  r_acc <= -r_prod;
            default: begin
            end
        endcase
        if (i_cmd.err_step) begin
            r_err   <= n_err;
            r_deriv <= fdpc_pkg::DERIV_W'(n_err) - fdpc_pkg::DERIV_W'(r_prev_err);
        end
        if (i_cmd.cmd_sat) begin
            r_cmd  <= fdpc_pkg::round_sat24(r_acc);
            r_coef <= r_prod[fdpc_pkg::COEF_W-1:0];
        end
        if (i_cmd.filt) begin
            r_out_pitch <= pitch_new;
            r_out_sp    <= r_setpoint;
            r_out_cmd   <= r_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint   <= '0;
            r_esum       <= '0;
            r_prev_err   <= '0;
            r_pitch_filt <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.sp_sat) begin
                r_setpoint <= fdpc_pkg::round_sat24(r_prod);
            end
            if (i_cmd.err_step) begin
                r_esum     <= n_esum;
                r_prev_err <= n_err;
            end
            if (i_cmd.filt) begin
                r_pitch_filt <= pitch_new;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    function automatic logic signed [fdpc_pkg::ERR_W-1:0] ERR_W_CAST(
        input logic signed [fdpc_pkg::SPEED_W-1:0] x
    );
        return {x[fdpc_pkg::SPEED_W-1], x};
    endfunction

    assign o_out_valid          = r_out_valid;
    assign o_pitch_cmd          = r_out_pitch;
    assign o_speed_setpoint_out = r_out_sp;
    assign o_speed_cmd_out      = r_out_cmd;

endmodule
`default_nettype wire

// ----- rtl/fdpc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Follow-distance pitch controller checker
// Port-level assertions on handshake behavior and tick sequencing.
// ============================================================================
module fdpc_checker (
    input wire                                  i_clk,
    input wire                                  i_rst_n,
    input wire                                  i_in_valid,
    input wire                                  i_in_ready,
    input wire                                  i_out_valid,
    input wire                                  i_out_ready,
    input wire [fdpc_pkg::PITCH_W-1:0]          i_pitch_cmd,
    input wire [fdpc_pkg::SPEED_W-1:0]          i_speed_setpoint_out,
    input wire [fdpc_pkg::SPEED_W-1:0]          i_speed_cmd_out
);

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_pitch_cmd)
            && $stable(i_speed_setpoint_out) && $stable(i_speed_cmd_out))
        else $error("result payload changed while stalled");

    // The block works on one tick at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in_ready)
        else $error("second request accepted while a tick is in work");

    // No result can be ready the cycle after a request is taken.
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !$rose(i_out_valid))
        else $error("result appeared too early");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind follow_distance_pitch_controller fdpc_checker u_fdpc_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_in_valid           (i_in.valid),
    .i_in_ready           (i_in.ready),
    .i_out_valid          (o_out.valid),
    .i_out_ready          (o_out.ready),
    .i_pitch_cmd          (o_out.pitch_cmd),
    .i_speed_setpoint_out (o_out.speed_setpoint_out),
    .i_speed_cmd_out      (o_out.speed_cmd_out)
);
`default_nettype wire
